>>> design/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, quiet while reset is asserted.
`define ASSERT_IMPLIES(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, quiet while reset is asserted.
`define ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> design/ipv4nh_pkg.sv
// ----------------------------------------------------------------------------
// ipv4nh_pkg
// Shared types, operation codes and index helpers for the next-hop selector.
// ----------------------------------------------------------------------------
package ipv4nh_pkg;

	localparam int NUM_IFACES = 8;
	localparam int OP_W       = 3;
	localparam int IDX_W      = 3;
	localparam int IP_W       = 32;
	localparam int SLOT_W     = (NUM_IFACES > 1) ? $clog2(NUM_IFACES) : 1;

	typedef logic [OP_W-1:0]   op_t;
	typedef logic [IDX_W-1:0]  idx_t;
	typedef logic [SLOT_W-1:0] slot_t;
	typedef logic [IP_W-1:0]   ip_t;

	localparam op_t OP_WRITE_IF  = 3'd0;
	localparam op_t OP_SET_DFLT  = 3'd1;
	localparam op_t OP_CLR_DFLT  = 3'd2;
	localparam op_t OP_READ_DFLT = 3'd3;
	localparam op_t OP_LOOKUP    = 3'd4;

	localparam slot_t LAST_SLOT = SLOT_W'(NUM_IFACES - 1);

	typedef struct packed {
		logic present;
		logic link;
		ip_t  addr;
		ip_t  mask;
	} entry_t;

	typedef struct packed {
		logic   we;
		slot_t  slot;
		entry_t data;
	} wr_req_t;

	function automatic logic idx_in_range(idx_t idx);
		logic [SLOT_W+IDX_W-1:0] wide;
		wide = {{SLOT_W{1'b0}}, idx};
		return wide < (SLOT_W + IDX_W)'(NUM_IFACES);
	endfunction

	function automatic slot_t to_slot(idx_t idx);
		logic [SLOT_W+IDX_W-1:0] wide;
		wide = {{SLOT_W{1'b0}}, idx};
		return wide[SLOT_W-1:0];
	endfunction

	function automatic idx_t to_idx(slot_t slot);
		logic [SLOT_W+IDX_W-1:0] wide;
		wide = {{IDX_W{1'b0}}, slot};
		return wide[IDX_W-1:0];
	endfunction

endpackage

>>> design/ipv4_next_hop_select.sv
// ----------------------------------------------------------------------------
// ipv4_next_hop_select
// IPv4 next-hop selection over a small interface table and one default route.
// ----------------------------------------------------------------------------
// A command is taken when start is high while busy is low; busy then stays
// high until the result is shown. Every command gives exactly one result,
// shown on ok, out_index and out_ip for a single cycle while done is high;
// there is no way to hold a result off, so capture it on that cycle. Write
// interface, set, clear and read default finish in the execute state and
// their result is registered from there. A lookup reads one table entry per
// cycle through a single network compare unit: it decodes, tries the
// preferred interface if one is named and in range, then scans the entries
// in order until one matches, and else falls back to the default route. The
// next command may be started in the cycle the result is shown.
module ipv4_next_hop_select (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  ipv4nh_pkg::op_t        op,
	input  ipv4nh_pkg::idx_t       iface_index,
	input  logic                   present,
	input  logic                   link_up,
	input  ipv4nh_pkg::ip_t        addr,
	input  ipv4nh_pkg::ip_t        mask,
	input  ipv4nh_pkg::ip_t        gateway,
	input  logic                   has_preferred,
	input  ipv4nh_pkg::idx_t       preferred_index,
	input  ipv4nh_pkg::ip_t        dest_ip,
	output logic                   done,
	output logic                   ok,
	output ipv4nh_pkg::idx_t       out_index,
	output ipv4nh_pkg::ip_t        out_ip
);

	// Table write request and single read port, driven by the sequencer.
	ipv4nh_pkg::wr_req_t wr;
	ipv4nh_pkg::slot_t   rd_slot;
	ipv4nh_pkg::entry_t  rd_entry;
	logic                hit;

	// Latched destination, held by the sequencer over the whole lookup.
	ipv4nh_pkg::ip_t     cmp_dest;

	// Sequencer: latch the command, walk preferred -> scan -> default route,
	// hold the default route and drop it when its interface has gone away.
	ipv4nh_ctrl u_ctrl (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.op              (op),
		.iface_index     (iface_index),
		.present         (present),
		.link_up         (link_up),
		.addr            (addr),
		.mask            (mask),
		.gateway         (gateway),
		.has_preferred   (has_preferred),
		.preferred_index (preferred_index),
		.dest_ip         (dest_ip),
		.busy            (busy),
		.done            (done),
		.ok              (ok),
		.out_index       (out_index),
		.out_ip          (out_ip),
		.wr              (wr),
		.rd_slot         (rd_slot),
		.cmp_dest        (cmp_dest),
		.rd_entry        (rd_entry),
		.hit             (hit)
	);

	// Interface table: present and link flags clear on reset.
	ipv4nh_table u_table (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (wr),
		.rd_slot  (rd_slot),
		.rd_entry (rd_entry)
	);

	// The one compare unit, reused for the preferred entry and every scan step.
	ipv4nh_match u_match (
		.ent  (rd_entry),
		.dest (cmp_dest),
		.hit  (hit)
	);

endmodule

>>> design/ipv4nh_table.sv
// ----------------------------------------------------------------------------
// ipv4nh_table
// Interface table: one write port, one read port at a single slot per cycle.
// ----------------------------------------------------------------------------
module ipv4nh_table (
	input  logic                clk,
	input  logic                arst_n,
	input  ipv4nh_pkg::wr_req_t wr,
	input  ipv4nh_pkg::slot_t   rd_slot,
	output ipv4nh_pkg::entry_t  rd_entry
);

	logic [ipv4nh_pkg::NUM_IFACES-1:0] present_q;
	logic [ipv4nh_pkg::NUM_IFACES-1:0] link_q;
	ipv4nh_pkg::ip_t                   addr_q [ipv4nh_pkg::NUM_IFACES];
	ipv4nh_pkg::ip_t                   mask_q [ipv4nh_pkg::NUM_IFACES];

	// Flags reset to empty; address and mask only matter once present is set.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			present_q <= '0;
			link_q    <= '0;
		end else if (wr.we) begin
			present_q[wr.slot] <= wr.data.present;
			link_q[wr.slot]    <= wr.data.link;
		end
	end

	always_ff @(posedge clk) begin
		if (wr.we) begin
			addr_q[wr.slot] <= wr.data.addr;
			mask_q[wr.slot] <= wr.data.mask;
		end
	end

	always_comb begin
		rd_entry.present = present_q[rd_slot];
		rd_entry.link    = link_q[rd_slot];
		rd_entry.addr    = addr_q[rd_slot];
		rd_entry.mask    = mask_q[rd_slot];
	end

endmodule

>>> design/ipv4nh_match.sv
// ----------------------------------------------------------------------------
// ipv4nh_match
// Shared network compare: is the destination on this entry's network.
// ----------------------------------------------------------------------------
module ipv4nh_match (
	input  ipv4nh_pkg::entry_t ent,
	input  ipv4nh_pkg::ip_t    dest,
	output logic               hit
);

	logic usable;
	logic net_eq;

	assign usable = ent.present && ent.link && (ent.addr != '0);

	// A zero mask matches the host address only.
	assign net_eq = (ent.mask == '0) ? (ent.addr == dest)
	                                 : (((ent.addr ^ dest) & ent.mask) == '0);

	assign hit = usable && net_eq;

endmodule

>>> design/ipv4nh_ctrl.sv
// ----------------------------------------------------------------------------
// ipv4nh_ctrl
// Sequencer: latches a command, steps the table, holds the default route.
// ----------------------------------------------------------------------------
module ipv4nh_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  ipv4nh_pkg::op_t     op,
	input  ipv4nh_pkg::idx_t    iface_index,
	input  logic                present,
	input  logic                link_up,
	input  ipv4nh_pkg::ip_t     addr,
	input  ipv4nh_pkg::ip_t     mask,
	input  ipv4nh_pkg::ip_t     gateway,
	input  logic                has_preferred,
	input  ipv4nh_pkg::idx_t    preferred_index,
	input  ipv4nh_pkg::ip_t     dest_ip,
	output logic                busy,
	output logic                done,
	output logic                ok,
	output ipv4nh_pkg::idx_t    out_index,
	output ipv4nh_pkg::ip_t     out_ip,
	output ipv4nh_pkg::wr_req_t wr,
	output ipv4nh_pkg::slot_t   rd_slot,
	output ipv4nh_pkg::ip_t     cmp_dest,
	input  ipv4nh_pkg::entry_t  rd_entry,
	input  logic                hit
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_EXEC = 3'd1;
	localparam logic [2:0] ST_PREF = 3'd2;
	localparam logic [2:0] ST_SCAN = 3'd3;
	localparam logic [2:0] ST_DFLT = 3'd4;

	localparam ipv4nh_pkg::slot_t SLOT_ONE = ipv4nh_pkg::SLOT_W'(1);

	logic [2:0]        state_q, state_d;
	ipv4nh_pkg::slot_t k_q, k_d;
	logic              dvalid_q, dvalid_d;
	ipv4nh_pkg::idx_t  dindex_q, dindex_d;
	ipv4nh_pkg::ip_t   dgw_q, dgw_d;
	logic              done_q, ok_q;
	ipv4nh_pkg::idx_t  oidx_q;
	ipv4nh_pkg::ip_t   oip_q;

	ipv4nh_pkg::op_t  op_q;
	ipv4nh_pkg::idx_t idx_q, pref_q;
	logic             wpresent_q, wlink_q, has_pref_q;
	ipv4nh_pkg::ip_t  waddr_q, wmask_q, gw_q, dest_q;

	logic             fin, fin_ok;
	ipv4nh_pkg::idx_t fin_idx;
	ipv4nh_pkg::ip_t  fin_ip;

	assign busy      = (state_q != ST_IDLE);
	assign done      = done_q;
	assign ok        = ok_q;
	assign out_index = oidx_q;
	assign out_ip    = oip_q;
	assign cmp_dest  = dest_q;

	// Hold the command for the whole operation.
	always_ff @(posedge clk) begin
		if (start && !busy) begin
			op_q       <= op;
			idx_q      <= iface_index;
			wpresent_q <= present;
			wlink_q    <= link_up;
			waddr_q    <= addr;
			wmask_q    <= mask;
			gw_q       <= gateway;
			has_pref_q <= has_preferred;
			pref_q     <= preferred_index;
			dest_q     <= dest_ip;
		end
	end

	always_comb begin
		case (state_q)
			ST_PREF: rd_slot = ipv4nh_pkg::to_slot(pref_q);
			ST_SCAN: rd_slot = k_q;
			default: rd_slot = ipv4nh_pkg::to_slot(dindex_q);
		endcase
	end

	always_comb begin
		wr.we           = (state_q == ST_EXEC) && (op_q == ipv4nh_pkg::OP_WRITE_IF) &&
		                  ipv4nh_pkg::idx_in_range(idx_q);
		wr.slot         = ipv4nh_pkg::to_slot(idx_q);
		wr.data.present = wpresent_q;
		wr.data.link    = wlink_q;
		wr.data.addr    = waddr_q;
		wr.data.mask    = wmask_q;
	end

	always_comb begin
		state_d  = state_q;
		k_d      = k_q;
		dvalid_d = dvalid_q;
		dindex_d = dindex_q;
		dgw_d    = dgw_q;
		fin      = 1'b0;
		fin_ok   = 1'b0;
		fin_idx  = '0;
		fin_ip   = '0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				case (op_q)
					ipv4nh_pkg::OP_WRITE_IF: begin
						fin    = 1'b1;
						fin_ok = ipv4nh_pkg::idx_in_range(idx_q);
					end
					ipv4nh_pkg::OP_SET_DFLT: begin
						fin = 1'b1;
						if ((gw_q != '0) && ipv4nh_pkg::idx_in_range(idx_q)) begin
							dvalid_d = 1'b1;
							dindex_d = idx_q;
							dgw_d    = gw_q;
							fin_ok   = 1'b1;
						end
					end
					ipv4nh_pkg::OP_CLR_DFLT: begin
						fin      = 1'b1;
						fin_ok   = 1'b1;
						dvalid_d = 1'b0;
						dindex_d = '0;
						dgw_d    = '0;
					end
					ipv4nh_pkg::OP_READ_DFLT: begin
						fin = 1'b1;
						if (dvalid_q && rd_entry.present) begin
							fin_ok  = 1'b1;
							fin_idx = dindex_q;
							fin_ip  = dgw_q;
						end else if (dvalid_q) begin
							dvalid_d = 1'b0;
							dindex_d = '0;
							dgw_d    = '0;
						end
					end
					ipv4nh_pkg::OP_LOOKUP: begin
						k_d     = '0;
						state_d = (has_pref_q && ipv4nh_pkg::idx_in_range(pref_q)) ?
						          ST_PREF : ST_SCAN;
					end
					default: begin
						fin = 1'b1;
					end
				endcase
			end
			ST_PREF: begin
				if (hit) begin
					fin     = 1'b1;
					fin_ok  = 1'b1;
					fin_idx = pref_q;
					fin_ip  = dest_q;
				end else begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (hit) begin
					fin     = 1'b1;
					fin_ok  = 1'b1;
					fin_idx = ipv4nh_pkg::to_idx(k_q);
					fin_ip  = dest_q;
				end else if (k_q == ipv4nh_pkg::LAST_SLOT) begin
					state_d = ST_DFLT;
				end else begin
					k_d = k_q + SLOT_ONE;
				end
			end
			ST_DFLT: begin
				fin = 1'b1;
				if (dvalid_q && !rd_entry.present) begin
					dvalid_d = 1'b0;
					dindex_d = '0;
					dgw_d    = '0;
				end else if (dvalid_q && rd_entry.link && (rd_entry.addr != '0) &&
				             (dgw_q != '0)) begin
					fin_ok  = 1'b1;
					fin_idx = dindex_q;
					fin_ip  = dgw_q;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
		if (fin) begin
			state_d = ST_IDLE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			k_q      <= '0;
			dvalid_q <= 1'b0;
			dindex_q <= '0;
			dgw_q    <= '0;
			done_q   <= 1'b0;
			ok_q     <= 1'b0;
			oidx_q   <= '0;
			oip_q    <= '0;
		end else begin
			state_q  <= state_d;
			k_q      <= k_d;
			dvalid_q <= dvalid_d;
			dindex_q <= dindex_d;
			dgw_q    <= dgw_d;
			done_q   <= fin;
			if (fin) begin
				ok_q   <= fin_ok;
				oidx_q <= fin_idx;
				oip_q  <= fin_ip;
			end
		end
	end

endmodule

>>> design/ipv4nh_checker.sv
// ----------------------------------------------------------------------------
// ipv4nh_checker
// Port-level checks on the command and result handshake of the selector.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ipv4nh_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             start,
	input logic             busy,
	input logic             done,
	input logic             ok,
	input ipv4nh_pkg::idx_t out_index,
	input ipv4nh_pkg::ip_t  out_ip
);

	// A transfer always raises busy, with no result shown, in the cycle after it.
	`ASSERT_NEXT(a_start_busy, clk, arst_n, start && !busy, busy && !done, "transfer did not raise busy")

	// The result cycle frees the block for the next command.
	`ASSERT_IMPLIES(a_done_idle, clk, arst_n, done, !busy, "result shown while still busy")

	// One result per command: never two strobes in a row.
	`ASSERT_NEXT(a_done_single, clk, arst_n, done, !done, "result strobe repeated")

	// A failed operation returns zeroed fields.
	`ASSERT_IMPLIES(a_fail_zero, clk, arst_n, done && !ok, (out_index == '0) && (out_ip == '0), "failed result carries data")

endmodule

bind ipv4_next_hop_select ipv4nh_checker u_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.done      (done),
	.ok        (ok),
	.out_index (out_index),
	.out_ip    (out_ip)
);
